@@ rtl/core/table_interpolator_with_hunt_unit_macros.svh @@
// Assertion macros for the table interpolator.
// Included by the top level; no other dependencies.
`ifndef TABLE_INTERPOLATOR_WITH_HUNT_UNIT_MACROS_SVH
`define TABLE_INTERPOLATOR_WITH_HUNT_UNIT_MACROS_SVH
`define TIH_ASSERT_IMPL(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (a) |-> (c)) else $error("assertion failed");
`define TIH_ASSERT_NEXT(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (a) |=> (c)) else $error("assertion failed");
`endif

@@ rtl/core/tih_pkg.sv @@
// Shared types and constants for the table interpolator.
// No dependencies.
package tih_pkg;
    localparam int TableDepth = 256;
    localparam int IdxW = 8;
    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_BIN  = 2'd1;
    localparam logic [1:0] REQ_HUNT = 2'd2;
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BELOW = 2'd1;
    localparam logic [1:0] ST_ABOVE = 2'd2;
    localparam logic [1:0] ST_ZERO  = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE, S_RD0, S_CHK0, S_CHKL, S_RDA, S_HDIR, S_HSTEP, S_HCHK,
        S_BLO, S_BHI, S_BCHK, S_BMID, S_BMCHK,
        S_RX0, S_RX1, S_RY0, S_RY1, S_MUL, S_DIV, S_FIN, S_OUT
    } state_t;
endpackage

@@ rtl/core/tih_if.sv @@
// Valid/ready channel interfaces for the table interpolator.
// Depends on nothing.
interface tih_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  entry_index;
    logic signed [31:0] entry_x;
    logic signed [31:0] entry_y;
    logic signed [31:0] query_x;
    modport source (output valid, req_type, entry_index, entry_x, entry_y, query_x,
                    input ready);
    modport sink (input valid, req_type, entry_index, entry_x, entry_y, query_x,
                  output ready);
endinterface

interface tih_rsp_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] interp_value;
    logic [7:0]  bracket_index;
    logic [1:0]  status;
    modport source (output valid, interp_value, bracket_index, status, input ready);
    modport sink (input valid, interp_value, bracket_index, status, output ready);
endinterface

interface tih_cfg_if;
    logic       valid;
    logic       ready;
    logic [8:0] point_count;
    modport source (output valid, point_count, input ready);
    modport sink (input valid, point_count, output ready);
endinterface

@@ rtl/core/table_interpolator_with_hunt_unit.sv @@
// Piecewise-linear interpolator with binary or hunting search over a table.
// Loads and unused requests answer in the cycle after acceptance; queries run a search
// at one table read per step, then a restoring divider that takes one product bit per
// cycle (skipped for zero width).
// Throughput: one transaction at a time; the next is taken once the result leaves.
// Reset: asynchronous active low; clears control, last bracket and point count 2.
`include "table_interpolator_with_hunt_unit_macros.svh"
module table_interpolator_with_hunt_unit (
    input  logic clk,
    input  logic rst_n,
    tih_req_if.sink   req,
    tih_rsp_if.source rsp,
    tih_cfg_if.sink   cfg
);
    localparam int IW = tih_pkg::IdxW;

    logic signed [31:0] x_mem [tih_pkg::TableDepth];
    logic signed [31:0] y_mem [tih_pkg::TableDepth];

    tih_pkg::state_t state_reg, state_next;
    logic [8:0] count_reg;
    logic [IW-1:0] last_reg, last_next;
    logic [1:0] type_reg;
    logic signed [31:0] q_reg;
    logic [IW-1:0] addr_reg, addr_next;
    logic signed [31:0] rd_reg;
    logic mem_y_next;
    logic [IW-1:0] lastn;
    logic [IW-1:0] a_reg, a_next, lo_reg, lo_next, hi_reg, hi_next;
    logic [IW:0] step_reg, step_next;
    logic dir_reg, dir_next; // 1: moving down
    logic signed [31:0] x0_reg, x0_next, x1_reg, x1_next, y0_reg, y0_next, y1_reg, y1_next;
    logic [1:0] st_reg, st_next;
    logic [63:0] prod_reg, prod_next;
    logic [32:0] d_reg, d_next;
    logic [33:0] rem_reg, rem_next;
    logic [33:0] quo_reg, quo_next;
    logic [6:0] cnt_reg, cnt_next;
    logic big_reg, big_next, neg_reg, neg_next;
    logic signed [31:0] val_reg, val_next;
    logic rsp_valid_reg, rsp_valid_next;

    logic signed [32:0] dq, dy, dx;
    logic [32:0] mq, my;
    logic [34:0] rsh;
    logic [34:0] rdiff;
    logic signed [35:0] sum;
    logic signed [35:0] tq;
    logic [IW-1:0] mid;
    logic [8:0] nclamp;

    assign nclamp = (count_reg < 9'd2) ? 9'd2
                  : (count_reg > 9'(tih_pkg::TableDepth)) ? 9'(tih_pkg::TableDepth)
                  : count_reg;
    assign lastn = IW'(nclamp - 9'd1);
    assign mid = IW'((9'(lo_reg) + 9'(hi_reg)) >> 1);

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready && req.req_type == tih_pkg::REQ_LOAD)
        begin
            x_mem[req.entry_index] <= req.entry_x;
            y_mem[req.entry_index] <= req.entry_y;
        end
        rd_reg <= mem_y_next ? y_mem[addr_next] : x_mem[addr_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tih_pkg::S_IDLE;
            count_reg <= 9'd2;
            last_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
                count_reg <= cfg.point_count;
            last_reg <= last_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            type_reg <= req.req_type;
            q_reg <= req.query_x;
        end
        addr_reg <= addr_next;
        a_reg <= a_next; lo_reg <= lo_next; hi_reg <= hi_next;
        step_reg <= step_next; dir_reg <= dir_next;
        x0_reg <= x0_next; x1_reg <= x1_next; y0_reg <= y0_next; y1_reg <= y1_next;
        st_reg <= st_next; prod_reg <= prod_next; d_reg <= d_next;
        rem_reg <= rem_next; quo_reg <= quo_next; cnt_reg <= cnt_next;
        big_reg <= big_next; neg_reg <= neg_next; val_reg <= val_next;
    end

    assign cfg.ready = (state_reg == tih_pkg::S_IDLE);
    assign req.ready = (state_reg == tih_pkg::S_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.interp_value = val_reg;
    assign rsp.bracket_index = lo_reg;
    assign rsp.status = st_reg;

    always_comb
    begin
        dq = 33'(q_reg) - 33'(x0_reg);
        dy = 33'(y1_reg) - 33'(y0_reg);
        dx = 33'(x1_reg) - 33'(x0_reg);
        mq = dq[32] ? 33'(-dq) : 33'(dq);
        my = dy[32] ? 33'(-dy) : 33'(dy);
        rsh = {rem_reg, prod_reg[63]};
        rdiff = rsh - 35'(d_reg);
        tq = neg_reg ? -36'(quo_reg) : 36'(quo_reg);
        sum = 36'(y0_reg) + tq;

        state_next = state_reg;
        last_next = last_reg;
        addr_next = addr_reg; mem_y_next = 1'b0;
        a_next = a_reg; lo_next = lo_reg; hi_next = hi_reg;
        step_next = step_reg; dir_next = dir_reg;
        x0_next = x0_reg; x1_next = x1_reg; y0_next = y0_reg; y1_next = y1_reg;
        st_next = st_reg; prod_next = prod_reg; d_next = d_reg;
        rem_next = rem_reg; quo_next = quo_reg; cnt_next = cnt_reg;
        big_next = big_reg; neg_next = neg_reg; val_next = val_reg;
        rsp_valid_next = rsp_valid_reg;

        case (state_reg)
            tih_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.req_type == tih_pkg::REQ_BIN || req.req_type == tih_pkg::REQ_HUNT)
                    begin
                        addr_next = '0;
                        state_next = tih_pkg::S_RD0;
                    end
                    else
                    begin
                        val_next = '0; lo_next = '0; st_next = tih_pkg::ST_OK;
                        rsp_valid_next = 1'b1;
                        state_next = tih_pkg::S_OUT;
                    end
                end
            end
            tih_pkg::S_RD0:
            begin
                // rd_reg now holds x[0]
                st_next = tih_pkg::ST_OK;
                if (q_reg < rd_reg)
                begin
                    lo_next = '0; st_next = tih_pkg::ST_BELOW;
                    state_next = tih_pkg::S_RX0;
                    addr_next = '0;
                end
                else
                begin
                    addr_next = lastn;
                    state_next = tih_pkg::S_CHKL;
                end
            end
            tih_pkg::S_CHKL:
            begin
                if (q_reg > rd_reg)
                begin
                    lo_next = lastn - 1'b1; st_next = tih_pkg::ST_ABOVE;
                    addr_next = lastn - 1'b1;
                    state_next = tih_pkg::S_RX0;
                end
                else if (type_reg == tih_pkg::REQ_BIN)
                begin
                    lo_next = '0; hi_next = lastn;
                    state_next = tih_pkg::S_BMID;
                end
                else
                begin
                    a_next = (last_reg > lastn - 1'b1) ? lastn - 1'b1 : last_reg;
                    addr_next = a_next;
                    state_next = tih_pkg::S_RDA;
                end
            end
            tih_pkg::S_RDA:
                state_next = tih_pkg::S_HDIR;
            tih_pkg::S_HDIR:
            begin
                step_next = (IW+1)'(1);
                dir_next = (q_reg < rd_reg);
                state_next = tih_pkg::S_HSTEP;
            end
            tih_pkg::S_HSTEP:
            begin
                // Issue the probe for the next hunt step, or stop at the bound.
                if (dir_reg)
                begin
                    if (a_reg == '0)
                    begin
                        lo_next = '0; hi_next = '0;
                        state_next = tih_pkg::S_BLO;
                        addr_next = '0;
                    end
                    else
                    begin
                        addr_next = ((IW+1)'(a_reg) >= step_reg) ? IW'((IW+1)'(a_reg) - step_reg)
                                                                 : '0;
                        state_next = tih_pkg::S_HCHK;
                    end
                end
                else
                begin
                    if (a_reg == lastn)
                    begin
                        lo_next = lastn; hi_next = lastn;
                        addr_next = lastn;
                        state_next = tih_pkg::S_BLO;
                    end
                    else
                    begin
                        addr_next = ((IW+1)'(lastn - a_reg) >= step_reg)
                                    ? IW'((IW+1)'(a_reg) + step_reg) : lastn;
                        state_next = tih_pkg::S_HCHK;
                    end
                end
            end
            tih_pkg::S_HCHK:
            begin
                if (dir_reg ? (q_reg < rd_reg) : (q_reg > rd_reg))
                begin
                    a_next = addr_reg;
                    step_next = step_reg << 1;
                    state_next = tih_pkg::S_HSTEP;
                end
                else
                begin
                    if (dir_reg)
                    begin
                        lo_next = addr_reg; hi_next = a_reg;
                    end
                    else
                    begin
                        lo_next = a_reg; hi_next = addr_reg;
                    end
                    addr_next = lo_next;
                    state_next = tih_pkg::S_BLO;
                end
            end
            tih_pkg::S_BLO:
            begin
                // rd_reg holds x[lo]; start the read of x[hi].
                dir_next = (q_reg >= rd_reg);
                addr_next = hi_reg;
                state_next = tih_pkg::S_BHI;
            end
            tih_pkg::S_BHI:
                state_next = tih_pkg::S_BCHK;
            tih_pkg::S_BCHK:
            begin
                if (dir_reg && q_reg <= rd_reg)
                    state_next = tih_pkg::S_BMID;
                else
                begin
                    if (lo_reg > lastn - 1'b1)
                        lo_next = lastn - 1'b1;
                    addr_next = lo_next;
                    state_next = tih_pkg::S_RX0;
                end
            end
            tih_pkg::S_BMID:
            begin
                if (9'(hi_reg) - 9'(lo_reg) > 9'd1)
                begin
                    addr_next = mid;
                    state_next = tih_pkg::S_BMCHK;
                end
                else
                begin
                    if (lo_reg > lastn - 1'b1)
                        lo_next = lastn - 1'b1;
                    addr_next = lo_next;
                    state_next = tih_pkg::S_RX0;
                end
            end
            tih_pkg::S_BMCHK:
            begin
                if (q_reg > rd_reg)
                    lo_next = addr_reg;
                else
                    hi_next = addr_reg;
                state_next = tih_pkg::S_BMID;
            end
            tih_pkg::S_RX0:
            begin
                last_next = lo_reg;
                x0_next = rd_reg;
                addr_next = lo_reg + 1'b1;
                state_next = tih_pkg::S_RX1;
            end
            tih_pkg::S_RX1:
            begin
                x1_next = rd_reg;
                addr_next = lo_reg; mem_y_next = 1'b1;
                state_next = tih_pkg::S_RY0;
            end
            tih_pkg::S_RY0:
            begin
                y0_next = rd_reg;
                addr_next = lo_reg + 1'b1; mem_y_next = 1'b1;
                state_next = tih_pkg::S_RY1;
            end
            tih_pkg::S_RY1:
            begin
                y1_next = rd_reg;
                state_next = tih_pkg::S_MUL;
            end
            tih_pkg::S_MUL:
            begin
                state_next = tih_pkg::S_DIV;
                cnt_next = 7'd0;
                rem_next = '0; quo_next = '0; big_next = 1'b0;
                if (x1_reg == x0_reg)
                begin
                    st_next = tih_pkg::ST_ZERO;
                    val_next = y0_reg;
                    rsp_valid_next = 1'b1;
                    state_next = tih_pkg::S_OUT;
                end
            end
            tih_pkg::S_DIV:
            begin
                // First cycle sets up the operands; then 64 bits of the product feed
                // the restoring divider, one bit a cycle.
                if (cnt_reg == 7'd0)
                begin
                    prod_next = 64'(mq) * 64'(my);
                    d_next = dx[32] ? 33'(-dx) : 33'(dx);
                    neg_next = (dq[32] ^ dy[32]) ^ dx[32];
                    cnt_next = 7'd1;
                end
                else
                begin
                    prod_next = prod_reg << 1;
                    if (rsh >= 35'(d_reg))
                    begin
                        rem_next = rdiff[33:0];
                        if (cnt_reg <= 7'd30)
                            big_next = 1'b1;
                        else
                            quo_next = {quo_reg[32:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rsh[33:0];
                        if (cnt_reg > 7'd30)
                            quo_next = {quo_reg[32:0], 1'b0};
                    end
                    cnt_next = cnt_reg + 7'd1;
                    if (cnt_reg == 7'd64)
                        state_next = tih_pkg::S_FIN;
                end
            end
            tih_pkg::S_FIN:
            begin
                if (big_reg)
                    val_next = neg_reg ? 32'sh8000_0000 : 32'sh7fff_ffff;
                else if (sum > 36'sd2147483647)
                    val_next = 32'sh7fff_ffff;
                else if (sum < -36'sd2147483648)
                    val_next = 32'sh8000_0000;
                else
                    val_next = sum[31:0];
                rsp_valid_next = 1'b1;
                state_next = tih_pkg::S_OUT;
            end
            tih_pkg::S_OUT:
            begin
                if (rsp.ready)
                begin
                    rsp_valid_next = 1'b0;
                    state_next = tih_pkg::S_IDLE;
                end
            end
            default:
                state_next = tih_pkg::S_IDLE;
        endcase
    end

    `TIH_ASSERT_IMPL(a_valid_in_out, rsp_valid_reg, state_reg == tih_pkg::S_OUT)
    `TIH_ASSERT_IMPL(a_no_take_busy, state_reg != tih_pkg::S_IDLE, !req.ready)
    `TIH_ASSERT_NEXT(a_hold, rsp.valid && !rsp.ready, $stable(rsp.interp_value))
endmodule
